// ===== sv/obstacle_list_fusion_unit_macros.svh =====
// assertion helpers for the obstacle list fusion unit
`ifndef OBSTACLE_LIST_FUSION_UNIT_MACROS_SVH
`define OBSTACLE_LIST_FUSION_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define OLF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/olf_pkg.sv =====
`default_nettype none
package olf_pkg;

  localparam logic [1:0] FuncLoadLocal  = 2'd0;
  localparam logic [1:0] FuncLoadRemote = 2'd1;
  localparam logic [1:0] FuncRun        = 2'd2;

  localparam logic [2:0] RegMatchDist  = 3'd0;
  localparam logic [2:0] RegFieldMin   = 3'd1;
  localparam logic [2:0] RegFieldMaxX  = 3'd2;
  localparam logic [2:0] RegFieldMaxY  = 3'd3;
  localparam logic [2:0] RegEmptyMark  = 3'd4;
  localparam logic [2:0] RegStaleLimit = 3'd5;

  localparam logic [2:0] StaleSat = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  slot;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [15:0] variance;
    logic [14:0] partner_x;
    logic [14:0] partner_y;
    logic        local_valid;
    logic        remote_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  entry_index;
    logic [14:0] enemy_x;
    logic [14:0] enemy_y;
    logic        fused;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [11:0] match_distance;
    logic [11:0] field_min;
    logic [14:0] field_max_x;
    logic [14:0] field_max_y;
    logic [14:0] empty_marker;
    logic [2:0]  stale_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic latch_run;   // capture run item
    logic filter;      // apply self/partner filters
    logic pair_step;   // evaluate pair (i,j); never asserted by olf_ctrl
    logic div_start;   // launch weighted means
    logic pair_write;  // write fused entry, clear pair
    logic fill_step;   // copy leftover detection at scan index
    logic zero_step;   // zero list entry at k
    logic emit;        // drive result at emit index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pair_hit;
    logic div_done;
    logic fill_hit;
    logic list_full;
  } sts_t;

  function automatic logic [14:0] abs_diff(input logic [14:0] a, input logic [14:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== sv/olf_wmean_div.sv =====
`default_nettype none
// restoring divider computing (a*wa + b*wb) / (wa+wb), one quotient bit per cycle
module olf_wmean_div
  import olf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [14:0] a_i,
  input  wire logic [15:0] wa_i,
  input  wire logic [14:0] b_i,
  input  wire logic [15:0] wb_i,
  output logic             done_o,
  output logic [14:0]      quot_o
);
  localparam int NumW = 32;
  localparam int DenW = 17;
  localparam int CntW = 6;

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            prod_q, prod_d;
  logic [30:0]     pa_q, pb_q, pa_d, pb_d;
  logic [DenW:0]   trial;

  assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    prod_d = 1'b0;
    pa_d   = pa_q;
    pb_d   = pb_q;
    done_o = 1'b0;
    if (start_i) begin
      // products registered first; zero weights keep the raw coordinates
      if ((wa_i == '0) && (wb_i == '0)) begin
        pa_d = {16'd0, a_i};
        pb_d = {16'd0, b_i};
      end else begin
        pa_d = a_i * wa_i;
        pb_d = b_i * wb_i;
      end
      den_d  = {1'b0, wa_i} + {1'b0, wb_i};
      prod_d = 1'b1;
    end else if (prod_q) begin
      if (den_q == '0) begin
        // plain mean finishes next cycle through zero count path
        num_d  = NumW'({1'b0, pa_q[14:0]} + {1'b0, pb_q[14:0]}) >> 1;
        rem_d  = '0;
        cnt_d  = '0;
        busy_d = 1'b1;
      end else begin
        num_d = NumW'({1'b0, pa_q} + {1'b0, pb_q});
        rem_d = '0;
        cnt_d = CntW'(NumW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          num_d = {num_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign quot_o = num_q[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      prod_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      prod_q <= prod_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
  end

endmodule
`default_nettype wire

// ===== sv/olf_datapath.sv =====
`default_nettype none
// detection lists, enemy list, pairing compare and output register
module olf_datapath
  import olf_pkg::*;
#(
  parameter int SLOTS = 4,
  parameter int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire in_item_t  item_i,
  input  wire logic      load_i,
  input  wire cmd_t      cmd_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic [IdxW-1:0] jdx_i,
  input  wire logic      scan_remote_i,
  input  wire logic      fused_i,
  output sts_t           sts_o,
  output logic           strobe_o,
  output out_item_t      result_o
);
  localparam int KW = $clog2(SLOTS + 1);

  logic [14:0] lx_q [SLOTS], ly_q [SLOTS], rx_q [SLOTS], ry_q [SLOTS];
  logic [15:0] lv_q [SLOTS], rv_q [SLOTS];
  logic [14:0] ex_q [SLOTS], ey_q [SLOTS];
  logic [14:0] px_q, py_q, qx_q, qy_q;
  logic [KW-1:0] k_q;
  logic        div_start, dx_done, dy_done;
  logic [14:0] qxo, qyo;
  logic        dflag_q;
  logic        strobe_q;
  out_item_t   res_q;

  function automatic logic near(input logic [14:0] ax, input logic [14:0] ay,
                                input logic [14:0] bx, input logic [14:0] by,
                                input logic [11:0] md);
    near = (abs_diff(ax, bx) < {3'd0, md}) && (abs_diff(ay, by) < {3'd0, md});
  endfunction

  // pairing and fill status
  assign sts_o.pair_hit  = (lx_q[idx_i] != '0) && (rx_q[jdx_i] != '0) &&
                           near(lx_q[idx_i], ly_q[idx_i], rx_q[jdx_i], ry_q[jdx_i],
                                cfg_i.match_distance);
  assign sts_o.fill_hit  = scan_remote_i ? (rx_q[idx_i] != '0) : (lx_q[idx_i] != '0);
  assign sts_o.list_full = (k_q == KW'(SLOTS));
  assign sts_o.div_done  = dflag_q;
  assign div_start       = cmd_i.div_start;

  olf_wmean_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start),
    .a_i(lx_q[idx_i]), .wa_i(lv_q[idx_i]), .b_i(rx_q[jdx_i]), .wb_i(rv_q[jdx_i]),
    .done_o(dx_done), .quot_o(qxo)
  );
  olf_wmean_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start),
    .a_i(ly_q[idx_i]), .wa_i(lv_q[idx_i]), .b_i(ry_q[jdx_i]), .wb_i(rv_q[jdx_i]),
    .done_o(dy_done), .quot_o(qyo)
  );

  // both dividers run in lockstep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflag_q  <= 1'b0;
      strobe_q <= 1'b0;
      k_q      <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        ex_q[s] <= '0;
        ey_q[s] <= '0;
      end
    end else begin
      dflag_q  <= dx_done & dy_done;
      strobe_q <= cmd_i.emit;
      if (cmd_i.latch_run) k_q <= '0;
      if (cmd_i.pair_write) begin
        ex_q[k_q[IdxW-1:0]] <= qxo;
        ey_q[k_q[IdxW-1:0]] <= qyo;
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.fill_step && sts_o.fill_hit && !sts_o.list_full) begin
        ex_q[k_q[IdxW-1:0]] <= scan_remote_i ? rx_q[idx_i] : lx_q[idx_i];
        ey_q[k_q[IdxW-1:0]] <= scan_remote_i ? ry_q[idx_i] : ly_q[idx_i];
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.zero_step && !sts_o.list_full) begin
        ex_q[k_q[IdxW-1:0]] <= '0;
        ey_q[k_q[IdxW-1:0]] <= '0;
        k_q <= k_q + 1'b1;
      end
    end
  end

  // detection store and run latch
  always_ff @(posedge clk_i) begin
    if (load_i && (32'(item_i.slot) < SLOTS)) begin
      if (item_i.func == FuncLoadLocal) begin
        lx_q[IdxW'(item_i.slot)] <= item_i.pos_x;
        ly_q[IdxW'(item_i.slot)] <= item_i.pos_y;
        lv_q[IdxW'(item_i.slot)] <= item_i.variance;
      end else if (item_i.func == FuncLoadRemote) begin
        rx_q[IdxW'(item_i.slot)] <= item_i.pos_x;
        ry_q[IdxW'(item_i.slot)] <= item_i.pos_y;
        rv_q[IdxW'(item_i.slot)] <= item_i.variance;
      end
    end
    if (cmd_i.latch_run) begin
      px_q <= item_i.pos_x;
      py_q <= item_i.pos_y;
      qx_q <= item_i.partner_x;
      qy_q <= item_i.partner_y;
    end
    if (cmd_i.filter) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (near(rx_q[s], ry_q[s], px_q, py_q, cfg_i.match_distance) &&
            rx_q[s] > {3'd0, cfg_i.field_min} && rx_q[s] < cfg_i.field_max_x &&
            ry_q[s] > {3'd0, cfg_i.field_min} && ry_q[s] < cfg_i.field_max_y) begin
          rx_q[s] <= cfg_i.empty_marker;
          ry_q[s] <= cfg_i.empty_marker;
        end
        if (near(lx_q[s], ly_q[s], qx_q, qy_q, cfg_i.match_distance)) begin
          lx_q[s] <= cfg_i.empty_marker;
          ly_q[s] <= cfg_i.empty_marker;
        end
      end
    end
    if (cmd_i.pair_write) begin
      lx_q[idx_i] <= '0;
      ly_q[idx_i] <= '0;
      rx_q[jdx_i] <= '0;
      ry_q[jdx_i] <= '0;
    end
    if (cmd_i.emit) begin
      res_q.entry_index <= 2'(idx_i);
      res_q.enemy_x     <= ex_q[idx_i];
      res_q.enemy_y     <= ey_q[idx_i];
      res_q.fused       <= fused_i;
      res_q.last        <= (32'(idx_i) == SLOTS - 1);
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== sv/olf_ctrl.sv =====
`default_nettype none
// sequencer: gate, filter, pairing walk, fill, zero and emit
module olf_ctrl
  import olf_pkg::*;
#(
  parameter int SLOTS = 4,
  parameter int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      run_i,
  input  wire logic      lval_i,
  input  wire logic      rval_i,
  input  wire logic [2:0] stale_limit_i,
  input  wire sts_t      sts_i,
  output cmd_t           cmd_o,
  output logic [IdxW-1:0] idx_o,
  output logic [IdxW-1:0] jdx_o,
  output logic           scan_remote_o,
  output logic           fused_o,
  output logic           busy_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFilt  = 3'd1;
  localparam logic [2:0] StPair  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StFill  = 3'd4;
  localparam logic [2:0] StZero  = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic            rem_q, rem_d, fused_q, fused_d, wait_q, wait_d;
  logic [2:0]      lst_q, lst_d, rst_q, rst_d;
  logic            do_fuse;

  assign do_fuse = (rval_i || rst_q > stale_limit_i) && (lval_i || lst_q > stale_limit_i);

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    rem_d = rem_q;
    fused_d = fused_q;
    wait_d = wait_q;
    lst_d = lst_q;
    rst_d = rst_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (run_i) begin
          cmd_o.latch_run = 1'b1;
          fused_d = do_fuse;
          i_d = '0;
          j_d = '0;
          rem_d = 1'b0;
          if (do_fuse) begin
            lst_d = '0;
            rst_d = '0;
            state_d = StFilt;
          end else begin
            if (!rval_i && rst_q < StaleSat) rst_d = rst_q + 1'b1;
            if (!lval_i && lst_q < StaleSat) lst_d = lst_q + 1'b1;
            state_d = StEmit;
          end
        end
      end
      StFilt: begin
        cmd_o.filter = 1'b1;
        state_d = StPair;
      end
      StPair: begin
        if (sts_i.pair_hit && !sts_i.list_full) begin
          cmd_o.div_start = 1'b1;
          wait_d = 1'b1;
          state_d = StDiv;
        end else if (j_q == LastIdx) begin
          j_d = '0;
          if (i_q == LastIdx) begin
            i_d = '0;
            state_d = StFill;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      StDiv: begin
        wait_d = 1'b0;
        if (sts_i.div_done && !wait_q) begin
          cmd_o.pair_write = 1'b1;
          j_d = '0;
          if (i_q == LastIdx) begin
            i_d = '0;
            state_d = StFill;
          end else begin
            i_d = i_q + 1'b1;
            state_d = StPair;
          end
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (i_q == LastIdx) begin
          i_d = '0;
          if (rem_q) state_d = StZero;
          rem_d = ~rem_q;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StZero: begin
        if (sts_i.list_full) begin
          state_d = StEmit;
        end else begin
          cmd_o.zero_step = 1'b1;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (i_q == LastIdx) begin
          i_d = '0;
          state_d = StIdle;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q <= '0;
      j_q <= '0;
      rem_q <= 1'b0;
      fused_q <= 1'b0;
      wait_q <= 1'b0;
      lst_q <= '0;
      rst_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      rem_q <= rem_d;
      fused_q <= fused_d;
      wait_q <= wait_d;
      lst_q <= lst_d;
      rst_q <= rst_d;
    end
  end

  assign idx_o = i_q;
  assign jdx_o = j_q;
  assign scan_remote_o = rem_q;
  assign fused_o = fused_q;
  assign busy_o = (state_q != StIdle);

  `include "obstacle_list_fusion_unit_macros.svh"

  `OLF_ASSERT_IMPL(a_stale_sat, 1'b1, (lst_q <= StaleSat) && (rst_q <= StaleSat), "stale count over limit")
  `OLF_ASSERT_NEXT(a_filter_then_pair, state_q == StFilt, state_q == StPair, "filter not followed by pairing")
  `OLF_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd_o.filter, cmd_o.div_start, cmd_o.pair_write, cmd_o.fill_step, cmd_o.zero_step, cmd_o.emit}), "overlapping commands")

endmodule
`default_nettype wire

// ===== sv/obstacle_list_fusion_unit.sv =====
`default_nettype none
// obstacle list fusion unit
// command channel: a transaction on in_i is taken at a clock edge with start
// high and busy low. func load local or load remote stores one detection
// and gives no result; func 3 is ignored. loads leave busy low and may
// come back to back.
// func run gates on validity flags and stale counters, then filters,
// pairs local with remote detections and fuses each pair by a
// variance-weighted mean, fills leftovers and zeros the rest.
// result channel: SLOTS entries (four by default), one per cycle, each
// marked by result_valid_o for a single cycle; the receiver cannot stall.
// kept list: the run goes straight to the emit state and each entry is
// registered from it, so the last entry shows in the cycle busy drops.
// fused run: a filter step, then a pairing step per (i,j), where a fused
// pair runs the bit-serial divider (a plain mean if both variances are
// zero) in place of its own and its row's remaining steps, then a fill
// scan of the local and then the remote list, zero steps and the emit.
// config: cfg_we_i, cfg_addr_i, cfg_wdata_i write one register per cycle.
// reset clears registers to defaults, stale counters and the fused list;
// detection slots are not reset and hold no defined value until loaded.
module obstacle_list_fusion_unit
  import olf_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_i,
  output logic            result_valid_o,
  output out_item_t       result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_addr_i,
  input  wire logic [14:0] cfg_wdata_i
);
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic [IdxW-1:0] idx, jdx;
  logic scan_remote, fused, accept;

  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_distance <= 12'd250;
      cfg_q.field_min      <= 12'd100;
      cfg_q.field_max_x    <= 15'd2900;
      cfg_q.field_max_y    <= 15'd1900;
      cfg_q.empty_marker   <= 15'd0;
      cfg_q.stale_limit    <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegMatchDist:  cfg_q.match_distance <= cfg_wdata_i[11:0];
        RegFieldMin:   cfg_q.field_min      <= cfg_wdata_i[11:0];
        RegFieldMaxX:  cfg_q.field_max_x    <= cfg_wdata_i;
        RegFieldMaxY:  cfg_q.field_max_y    <= cfg_wdata_i;
        RegEmptyMark:  cfg_q.empty_marker   <= cfg_wdata_i;
        RegStaleLimit: cfg_q.stale_limit    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  olf_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i, .rst_ni,
    .run_i(accept && (in_i.func == FuncRun)),
    .lval_i(in_i.local_valid), .rval_i(in_i.remote_valid),
    .stale_limit_i(cfg_q.stale_limit),
    .sts_i(sts), .cmd_o(cmd), .idx_o(idx), .jdx_o(jdx),
    .scan_remote_o(scan_remote), .fused_o(fused), .busy_o(busy)
  );

  olf_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .item_i(in_i), .load_i(accept),
    .cmd_i(cmd), .idx_i(idx), .jdx_i(jdx), .scan_remote_i(scan_remote),
    .fused_i(fused), .sts_o(sts), .strobe_o(result_valid_o), .result_o(result_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import olf_pkg::*;

  localparam int NumSlots = 4;
  localparam int IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    in_i;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [14:0] cfg_wdata_i;

  obstacle_list_fusion_unit #(.SLOTS(NumSlots)) DUT (
    .clk_i, .rst_ni, .start, .busy, .in_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  // predictor copy of registers and lists
  int unsigned match_dist, fmin, fmax_x, fmax_y, empty_mark, stale_lim;
  int unsigned loc_x[NumSlots], loc_y[NumSlots], loc_v[NumSlots];
  int unsigned rem_x[NumSlots], rem_y[NumSlots], rem_v[NumSlots];
  int unsigned enemy_x[NumSlots], enemy_y[NumSlots];
  int unsigned loc_stale, rem_stale;

  // generator memory of last loaded positions, used to aim filters
  int unsigned gen_lx[NumSlots], gen_ly[NumSlots], gen_rx[NumSlots], gen_ry[NumSlots];

  in_item_t  pending_q[$];
  out_item_t entry_q[$];
  int        mismatches;
  int        idle_cycles;
  int        burst_left;
  int        gap_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_of(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit close_to(int unsigned ax, int unsigned ay,
                                  int unsigned bx, int unsigned by);
    return gap_of(ax, bx) < match_dist && gap_of(ay, by) < match_dist;
  endfunction

  function automatic int unsigned weighted_mean(int unsigned a, int unsigned wa,
                                                int unsigned b, int unsigned wb);
    longint unsigned den;
    den = longint'(wa) + longint'(wb);
    if (den == 0) return (a + b) / 2;
    return int'((longint'(a) * wa + longint'(b) * wb) / den);
  endfunction

  // filter, pair, fill and zero the opponent list
  function automatic void merge_lists(int unsigned px, int unsigned py,
                                      int unsigned qx, int unsigned qy);
    int k;
    k = 0;
    for (int i = 0; i < NumSlots; i++) begin
      if (close_to(rem_x[i], rem_y[i], px, py) && rem_x[i] > fmin && rem_x[i] < fmax_x &&
          rem_y[i] > fmin && rem_y[i] < fmax_y) begin
        rem_x[i] = empty_mark;
        rem_y[i] = empty_mark;
      end
      if (close_to(loc_x[i], loc_y[i], qx, qy)) begin
        loc_x[i] = empty_mark;
        loc_y[i] = empty_mark;
      end
    end
    for (int i = 0; i < NumSlots; i++) begin
      for (int j = 0; j < NumSlots; j++) begin
        if (loc_x[i] != 0 && rem_x[j] != 0 && close_to(loc_x[i], loc_y[i], rem_x[j], rem_y[j])
            && k < NumSlots) begin
          enemy_x[k] = weighted_mean(loc_x[i], loc_v[i], rem_x[j], rem_v[j]) & 32'h7fff;
          enemy_y[k] = weighted_mean(loc_y[i], loc_v[i], rem_y[j], rem_v[j]) & 32'h7fff;
          k++;
          loc_x[i] = 0; loc_y[i] = 0;
          rem_x[j] = 0; rem_y[j] = 0;
          break;
        end
      end
    end
    for (int i = 0; i < NumSlots; i++)
      if (loc_x[i] != 0 && k < NumSlots) begin
        enemy_x[k] = loc_x[i]; enemy_y[k] = loc_y[i]; k++;
      end
    for (int i = 0; i < NumSlots; i++)
      if (rem_x[i] != 0 && k < NumSlots) begin
        enemy_x[k] = rem_x[i]; enemy_y[k] = rem_y[i]; k++;
      end
    for (; k < NumSlots; k++) begin
      enemy_x[k] = 0; enemy_y[k] = 0;
    end
  endfunction

  // apply one accepted transaction, queue the list entries it produces
  function automatic void predict_item(in_item_t it);
    bit do_fuse;
    out_item_t e;
    if (it.func == FuncLoadLocal) begin
      loc_x[it.slot] = it.pos_x; loc_y[it.slot] = it.pos_y; loc_v[it.slot] = it.variance;
    end else if (it.func == FuncLoadRemote) begin
      rem_x[it.slot] = it.pos_x; rem_y[it.slot] = it.pos_y; rem_v[it.slot] = it.variance;
    end else if (it.func == FuncRun) begin
      do_fuse = (it.remote_valid || rem_stale > stale_lim) &&
                (it.local_valid || loc_stale > stale_lim);
      if (do_fuse) begin
        merge_lists(it.pos_x, it.pos_y, it.partner_x, it.partner_y);
        loc_stale = 0;
        rem_stale = 0;
      end else begin
        if (!it.remote_valid && rem_stale < StaleSat) rem_stale++;
        if (!it.local_valid && loc_stale < StaleSat) loc_stale++;
      end
      for (int i = 0; i < NumSlots; i++) begin
        e.entry_index = 2'(i);
        e.enemy_x     = 15'(enemy_x[i]);
        e.enemy_y     = 15'(enemy_y[i]);
        e.fused       = do_fuse;
        e.last        = (i == NumSlots - 1);
        entry_q.push_back(e);
      end
    end
  endfunction

  function automatic in_item_t mk(logic [1:0] f, logic [1:0] s, int unsigned x, int unsigned y,
                                  int unsigned v, int unsigned qx, int unsigned qy,
                                  bit lv, bit rv);
    in_item_t it;
    it.func = f; it.slot = s; it.pos_x = 15'(x); it.pos_y = 15'(y);
    it.variance = 16'(v); it.partner_x = 15'(qx); it.partner_y = 15'(qy);
    it.local_valid = lv; it.remote_valid = rv;
    return it;
  endfunction

  // mostly clustered coordinates so that pairs match, sometimes full range
  function automatic int unsigned rand_coord();
    int unsigned centers[4] = '{300, 1000, 1700, 2600};
    if ($urandom_range(0, 9) < 2) return $urandom_range(0, 32767);
    return centers[$urandom_range(0, 3)] + $urandom_range(0, 400);
  endfunction

  function automatic int unsigned rand_var();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int unsigned jitter(int unsigned c);
    return (c + $urandom_range(0, 300) > 150) ? c + $urandom_range(0, 300) - 150 : c;
  endfunction

  function automatic in_item_t rand_run();
    int unsigned r, p;
    r = $urandom_range(0, NumSlots - 1);
    p = $urandom_range(0, NumSlots - 1);
    return mk(FuncRun, 2'($urandom()), jitter(gen_rx[r]) & 32'h7fff,
              jitter(gen_ry[r]) & 32'h7fff,
              $urandom_range(0, 65535), jitter(gen_lx[p]) & 32'h7fff,
              jitter(gen_ly[p]) & 32'h7fff,
              $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
  endfunction

  // well-formed frames (load both lists, then run) plus some noise
  task automatic queue_random(int count);
    int n;
    int unsigned x, y;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        for (int s = 0; s < NumSlots; s++) begin
          x = rand_coord(); y = rand_coord();
          if ($urandom_range(0, 9) == 0) x = 0;
          gen_lx[s] = x; gen_ly[s] = y;
          pending_q.push_back(mk(FuncLoadLocal, 2'(s), x, y, rand_var(),
                                 $urandom(), $urandom(), $urandom(), $urandom()));
          x = ($urandom_range(0, 2) == 0) ? jitter(x) & 32'h7fff : rand_coord();
          y = ($urandom_range(0, 2) == 0) ? jitter(y) & 32'h7fff : rand_coord();
          gen_rx[s] = x; gen_ry[s] = y;
          pending_q.push_back(mk(FuncLoadRemote, 2'(s), x, y, rand_var(),
                                 $urandom(), $urandom(), $urandom(), $urandom()));
        end
        pending_q.push_back(rand_run());
        n += 2 * NumSlots + 1;
      end else begin
        case ($urandom_range(0, 2))
          0: pending_q.push_back(mk(3, 2'($urandom()), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom(), $urandom(), $urandom()));
          1: pending_q.push_back(mk(2'($urandom_range(0, 1)), 2'($urandom()),
                                    $urandom_range(0, 32767), $urandom_range(0, 32767),
                                    rand_var(), $urandom(), $urandom(), $urandom(),
                                    $urandom()));
          default: pending_q.push_back(rand_run());
        endcase
        n++;
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= 15'(val);
    case (idx)
      RegMatchDist:  match_dist = val & 32'hfff;
      RegFieldMin:   fmin       = val & 32'hfff;
      RegFieldMaxX:  fmax_x     = val & 32'h7fff;
      RegFieldMaxY:  fmax_y     = val & 32'h7fff;
      RegEmptyMark:  empty_mark = val & 32'h7fff;
      RegStaleLimit: stale_lim  = val & 32'h7;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned md, int unsigned mn, int unsigned mx, int unsigned my,
                           int unsigned em, int unsigned sl);
    write_reg(RegMatchDist, md);
    write_reg(RegFieldMin, mn);
    write_reg(RegFieldMaxX, mx);
    write_reg(RegFieldMaxY, my);
    write_reg(RegEmptyMark, em);
    write_reg(RegStaleLimit, sl);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_q.size() != 0 || start || entry_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // stimulus and phases
  initial begin
    rst_ni = 1'b0; start = 1'b0; in_i = '0;
    cfg_we_i = 1'b0; cfg_addr_i = '0; cfg_wdata_i = '0;
    match_dist = 250; fmin = 100; fmax_x = 2900; fmax_y = 1900; empty_mark = 0; stale_lim = 3;
    loc_stale = 0; rem_stale = 0;
    foreach (enemy_x[i]) begin
      enemy_x[i] = 0; enemy_y[i] = 0;
      loc_x[i] = 0; loc_y[i] = 0; loc_v[i] = 0; rem_x[i] = 0; rem_y[i] = 0; rem_v[i] = 0;
      gen_lx[i] = 500; gen_ly[i] = 500; gen_rx[i] = 500; gen_ry[i] = 500;
    end
    mismatches = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero weights, empty slots, filters, stale gating
    pending_q.push_back(mk(FuncRun, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadLocal, 0, 32767, 32767, 65535, 32767, 32767, 1, 1));
    pending_q.push_back(mk(FuncLoadRemote, 0, 32700, 32700, 65535, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadLocal, 1, 0, 700, 10, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadRemote, 1, 1000, 1000, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadLocal, 2, 1001, 1100, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadRemote, 2, 500, 500, 7, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadLocal, 3, 2000, 300, 3, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncLoadRemote, 3, 1200, 1200, 9, 0, 0, 0, 0));
    pending_q.push_back(mk(3, 3, 32767, 32767, 65535, 32767, 32767, 1, 1));
    pending_q.push_back(mk(FuncRun, 0, 0, 0, 0, 0, 0, 0, 1));
    pending_q.push_back(mk(FuncRun, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_q.push_back(mk(FuncRun, 3, 510, 490, 0, 2010, 290, 1, 1));
    for (int i = 0; i < 6; i++)
      pending_q.push_back(mk(FuncRun, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(FuncRun, 0, 32767, 32767, 65535, 32767, 32767, 0, 0));
    queue_random(18);
    wait_drained();

    write_all(4095, 0, 32767, 32767, 32767, 5);
    for (int i = 0; i < 7; i++)
      pending_q.push_back(mk(FuncRun, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_random(18);
    wait_drained();

    write_all(0, 4095, 0, 0, 0, 0);
    queue_random(10);
    wait_drained();

    write_all($urandom_range(100, 600), $urandom_range(0, 400), $urandom_range(1500, 4000),
              $urandom_range(1500, 4000), $urandom_range(0, 1) * $urandom_range(1, 32767),
              $urandom_range(0, 5));
    queue_random(18);
    wait_drained();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    if (!rst_ni) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      go = 1'b0;
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        go = 1'b1;
        in_i <= pending_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      start <= go;
    end
  end

  // monitor: check list entries, then predict newly accepted transactions
  always @(posedge clk_i) begin
    out_item_t want;
    bit active;
    if (rst_ni) begin
      active = 1'b0;
      if (result_valid_o) begin
        active = 1'b1;
        if (entry_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected entry %p", result_o);
        end else begin
          want = entry_q.pop_front();
          if (result_o.entry_index !== want.entry_index || result_o.enemy_x !== want.enemy_x ||
              result_o.enemy_y !== want.enemy_y || result_o.fused !== want.fused ||
              result_o.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) $display("entry mismatch: expected %p got %p", want, result_o);
          end
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        predict_item(in_i);
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
